// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, idle while reset is high
`define UVS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked check that a condition never occurs
`define UVS_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ===== rtl/uvs_pkg.sv =====
`timescale 1ns / 1ps

package uvs_pkg;

   // index and angle formats
   localparam int INDEX_BITS    = 10;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 24;
   localparam int CORDIC_USED   = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int CORDIC_BITS   = 32;
   localparam int ANGLE_BITS    = 32;
   localparam int TEX_BITS      = 16;
   localparam int HI_BITS       = INDEX_BITS + 1;
   localparam int REM_BITS      = INDEX_BITS + 1;
   localparam int DIV_STAGES    = HI_BITS + ANGLE_BITS;
   localparam int TEX_START     = DIV_STAGES - TEX_BITS;

   // field widths
   localparam int RADIUS_BITS = 16;
   localparam int NORM_BITS   = 16;
   localparam int POS_BITS    = 17;
   localparam int PROD_BITS   = 2 * CORDIC_BITS;
   localparam int MUL_BITS    = RADIUS_BITS + 1 + NORM_BITS;

   // bus widths
   localparam int REQ_DATA_BITS  = ((2 * INDEX_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 3 * POS_BITS + 3 * NORM_BITS + 2 * TEX_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // reset values
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 16'd256;
   localparam logic [INDEX_BITS-1:0]  SECTOR_RESET = INDEX_BITS'(32);
   localparam logic [INDEX_BITS-1:0]  STACK_RESET  = INDEX_BITS'(16);

   // CORDIC start value, gain compensated, Q2.30
   localparam logic signed [CORDIC_BITS-1:0] CORDIC_X0 = 32'sh26DD3B6A;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RADIUS  = 2'd0,
      CSR_SECTORS = 2'd1,
      CSR_STACKS  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // live configuration, counts already forced to at least one
   typedef struct packed {
      logic [RADIUS_BITS-1:0] radius;
      logic [INDEX_BITS-1:0]  sectors;
      logic [INDEX_BITS-1:0]  stacks;
   } cfg_type;

   // classified vertex request
   typedef struct packed {
      logic [INDEX_BITS-1:0] ring;
      logic [INDEX_BITS-1:0] sector;
      logic                  oor;
      logic                  u_clamp;
      logic                  v_clamp;
   } work_type;

   // atan(2^-i) in turns, Q0.32
   function automatic logic signed [CORDIC_BITS-1:0] atan_turn(input int unsigned i);
      logic signed [CORDIC_BITS-1:0] r;
      case (i)
         0:  r = 32'sd536870912;
         1:  r = 32'sd316933406;
         2:  r = 32'sd167458907;
         3:  r = 32'sd85004756;
         4:  r = 32'sd42667331;
         5:  r = 32'sd21354465;
         6:  r = 32'sd10679838;
         7:  r = 32'sd5340245;
         8:  r = 32'sd2670163;
         9:  r = 32'sd1335087;
         10: r = 32'sd667544;
         11: r = 32'sd333772;
         12: r = 32'sd166886;
         13: r = 32'sd83443;
         14: r = 32'sd41722;
         15: r = 32'sd20861;
         16: r = 32'sd10430;
         17: r = 32'sd5215;
         18: r = 32'sd2608;
         19: r = 32'sd1304;
         20: r = 32'sd652;
         21: r = 32'sd326;
         22: r = 32'sd163;
         23: r = 32'sd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/uvs_front.sv =====
`timescale 1ns / 1ps

module uvs_front (
   input  logic                             clock,
   input  logic                             reset,
   input  uvs_pkg::cfg_type                 cfg,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [uvs_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                             push_valid,
   input  logic                             push_ready,
   output uvs_pkg::work_type                push_item
);

   logic              valid_ff, valid_in;
   uvs_pkg::work_type item_ff, item_in;

   // one holding stage ahead of the queue
   assign req_tready = !valid_ff || push_ready;

   // split the indices and flag the ones past their count
   always_comb begin
      item_in.ring    = req_tdata[uvs_pkg::INDEX_BITS-1:0];
      item_in.sector  = req_tdata[2*uvs_pkg::INDEX_BITS-1:uvs_pkg::INDEX_BITS];
      item_in.v_clamp = item_in.ring > cfg.stacks;
      item_in.u_clamp = item_in.sector > cfg.sectors;
      item_in.oor     = item_in.v_clamp || item_in.u_clamp;
   end

   assign valid_in = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

// ===== rtl/uvs_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uvs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  uvs_pkg::work_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output uvs_pkg::work_type pop_item
);

   uvs_pkg::work_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push_fire, pop_fire;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push_fire ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_fire ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_fire} - {1'b0, pop_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `UVS_ASSERT_NEVER(a_queue_overfill, count_ff == 2'd3, "queue count past depth")
   `UVS_ASSERT(a_queue_grows, (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + 2'd1), "queue count did not grow on push")

endmodule

// ===== rtl/uvs_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uvs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  uvs_pkg::cfg_type                  cfg,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  uvs_pkg::work_type                 pop_item,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [uvs_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tuser
);

   localparam int IB = uvs_pkg::INDEX_BITS;
   localparam int RB = uvs_pkg::REM_BITS;
   localparam int AB = uvs_pkg::ANGLE_BITS;
   localparam int TB = uvs_pkg::TEX_BITS;
   localparam int CB = uvs_pkg::CORDIC_BITS;
   localparam int PB = uvs_pkg::PROD_BITS;
   localparam int NB = uvs_pkg::NORM_BITS;
   localparam int MB = uvs_pkg::MUL_BITS;
   localparam int DS = uvs_pkg::DIV_STAGES;
   localparam int CS = uvs_pkg::CORDIC_USED;
   localparam int RB_RAD = uvs_pkg::RADIUS_BITS + 1;

   localparam logic signed [PB-1:0] PROD_HALF = 64'sd1 <<< 44;
   localparam logic signed [CB-1:0] CT_HALF   = 32'sd16384;
   localparam logic signed [MB-1:0] POS_HALF  = MB'(16384);
   localparam logic signed [PB-1:0] NORM_MAX  = PB'(2 ** (NB - 1) - 1);
   localparam logic signed [PB-1:0] NORM_MIN  = -(PB'(2 ** (NB - 1)));
   localparam logic [TB-1:0]        TEX_ONE   = TB'(2 ** (TB - 1));

   typedef struct packed {
      logic [IB-1:0] ring;
      logic [IB-1:0] sector;
      logic [RB-1:0] ra;
      logic [RB-1:0] rb;
      logic [RB-1:0] ru;
      logic [RB-1:0] rv;
      logic [AB-1:0] qa;
      logic [AB-1:0] qb;
      logic [TB-1:0] qu;
      logic [TB-1:0] qv;
      logic          oor;
      logic          u_clamp;
      logic          v_clamp;
   } div_type;

   typedef struct packed {
      logic signed [CB-1:0] xt;
      logic signed [CB-1:0] yt;
      logic signed [CB-1:0] zt;
      logic signed [CB-1:0] xp;
      logic signed [CB-1:0] yp;
      logic signed [CB-1:0] zp;
      uvs_pkg::quad_type    qt;
      uvs_pkg::quad_type    qp;
      logic [TB-1:0]        qu;
      logic [TB-1:0]        qv;
      logic                 oor;
      logic                 u_clamp;
      logic                 v_clamp;
   } cor_type;

   typedef struct packed {
      logic signed [PB-1:0] px;
      logic signed [PB-1:0] py;
      logic signed [CB-1:0] ct;
      logic [TB-1:0]        qu;
      logic [TB-1:0]        qv;
      logic                 oor;
      logic                 u_clamp;
      logic                 v_clamp;
   } prod_type;

   typedef struct packed {
      logic signed [NB-1:0] nx;
      logic signed [NB-1:0] ny;
      logic signed [NB-1:0] nz;
      logic [TB-1:0]        qu;
      logic [TB-1:0]        qv;
      logic                 oor;
      logic                 u_clamp;
      logic                 v_clamp;
   } norm_type;

   typedef struct packed {
      logic signed [MB-1:0] mx;
      logic signed [MB-1:0] my;
      logic signed [MB-1:0] mz;
      norm_type             n;
   } mul_type;

   // one restoring divide step: {quotient bit, new remainder}
   function automatic logic [RB:0] div_step(input logic [RB-1:0] r, input logic b,
                                             input logic [RB-1:0] d);
      logic [RB:0] t;
      logic [RB:0] res;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         res = {1'b1, RB'(t - {1'b0, d})};
      end else begin
         res = {1'b0, t[RB-1:0]};
      end
      return res;
   endfunction

   // quadrant fold of a CORDIC result: {cos, sin}
   function automatic logic [2*CB-1:0] quad_map(input uvs_pkg::quad_type q,
                                                input logic signed [CB-1:0] x,
                                                input logic signed [CB-1:0] y);
      logic [2*CB-1:0] res;
      unique case (q)
         uvs_pkg::QUAD_0: res = {x, y};
         uvs_pkg::QUAD_1: res = {-y, x};
         uvs_pkg::QUAD_2: res = {-x, -y};
         uvs_pkg::QUAD_3: res = {y, -x};
         default:         res = {x, y};
      endcase
      return res;
   endfunction

   function automatic logic signed [NB-1:0] sat_q15(input logic signed [PB-1:0] v);
      logic signed [NB-1:0] res;
      if (v > NORM_MAX) begin
         res = NORM_MAX[NB-1:0];
      end else if (v < NORM_MIN) begin
         res = NORM_MIN[NB-1:0];
      end else begin
         res = v[NB-1:0];
      end
      return res;
   endfunction

   logic adv;
   logic [DS:0] dv_ff;
   logic [CS:0] cv_ff;
   logic        pv_ff, nv_ff, mv_ff, out_valid_ff;

   div_type  div_ff [0:DS];
   cor_type  cor_ff [0:CS];
   prod_type prod_ff, prod_in;
   norm_type norm_ff, norm_in;
   mul_type  mul_ff, mul_in;
   logic [uvs_pkg::RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   logic                              out_user_ff;

   logic [RB-1:0] d_st, d_se;
   logic [AB-1:0] st_low, se_low;
   logic [TB-1:0] st_tex, se_tex;

   // the whole pipe moves unless the output register is held
   assign adv       = !out_valid_ff || rsp_tready;
   assign pop_ready = adv;

   assign d_st   = {cfg.stacks, 1'b0};
   assign d_se   = {cfg.sectors, 1'b0};
   assign st_low = AB'(cfg.stacks);
   assign se_low = AB'(cfg.sectors);
   assign st_tex = TB'(cfg.stacks);
   assign se_tex = TB'(cfg.sectors);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff        <= '0;
         cv_ff        <= '0;
         pv_ff        <= 1'b0;
         nv_ff        <= 1'b0;
         mv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         dv_ff        <= {dv_ff[DS-1:0], pop_valid};
         cv_ff        <= {cv_ff[CS-1:0], dv_ff[DS]};
         pv_ff        <= cv_ff[CS];
         nv_ff        <= pv_ff;
         mv_ff        <= nv_ff;
         out_valid_ff <= mv_ff;
      end
   end

   // divider entry
   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0].ring    <= pop_item.ring;
         div_ff[0].sector  <= pop_item.sector;
         div_ff[0].ra      <= '0;
         div_ff[0].rb      <= '0;
         div_ff[0].ru      <= {1'b0, pop_item.sector};
         div_ff[0].rv      <= {1'b0, pop_item.ring};
         div_ff[0].qa      <= '0;
         div_ff[0].qb      <= '0;
         div_ff[0].qu      <= '0;
         div_ff[0].qv      <= '0;
         div_ff[0].oor     <= pop_item.oor;
         div_ff[0].u_clamp <= pop_item.u_clamp;
         div_ff[0].v_clamp <= pop_item.v_clamp;
      end
   end

   // long division, one quotient bit per stage; angle dividers reduce the
   // integer part first, texture dividers run over the last stages
   for (genvar k = 0; k < DS; k++) begin : g_div
      logic          bit_a, bit_b;
      logic [RB:0]   step_a, step_b;
      logic [RB-1:0] ru_nxt, rv_nxt;
      logic [TB-1:0] qu_nxt, qv_nxt;
      div_type       nxt;

      if (k < uvs_pkg::HI_BITS) begin : g_hi
         logic [uvs_pkg::HI_BITS-1:0] hi_a, hi_b;
         assign hi_a  = {1'b0, div_ff[k].ring};
         assign hi_b  = {div_ff[k].sector, 1'b0};
         assign bit_a = hi_a[uvs_pkg::HI_BITS-1-k];
         assign bit_b = hi_b[uvs_pkg::HI_BITS-1-k];
      end else begin : g_lo
         assign bit_a = st_low[AB-1-(k-uvs_pkg::HI_BITS)];
         assign bit_b = se_low[AB-1-(k-uvs_pkg::HI_BITS)];
      end

      assign step_a = div_step(div_ff[k].ra, bit_a, d_st);
      assign step_b = div_step(div_ff[k].rb, bit_b, d_se);

      if (k >= uvs_pkg::TEX_START) begin : g_tex
         logic [RB:0] step_u, step_v;
         assign step_u = div_step(div_ff[k].ru, se_tex[TB-1-(k-uvs_pkg::TEX_START)], d_se);
         assign step_v = div_step(div_ff[k].rv, st_tex[TB-1-(k-uvs_pkg::TEX_START)], d_st);
         assign ru_nxt = step_u[RB-1:0];
         assign rv_nxt = step_v[RB-1:0];
         assign qu_nxt = {div_ff[k].qu[TB-2:0], step_u[RB]};
         assign qv_nxt = {div_ff[k].qv[TB-2:0], step_v[RB]};
      end else begin : g_wait
         assign ru_nxt = div_ff[k].ru;
         assign rv_nxt = div_ff[k].rv;
         assign qu_nxt = div_ff[k].qu;
         assign qv_nxt = div_ff[k].qv;
      end

      always_comb begin
         nxt    = div_ff[k];
         nxt.ra = step_a[RB-1:0];
         nxt.rb = step_b[RB-1:0];
         nxt.qa = {div_ff[k].qa[AB-2:0], step_a[RB]};
         nxt.qb = {div_ff[k].qb[AB-2:0], step_b[RB]};
         nxt.ru = ru_nxt;
         nxt.rv = rv_nxt;
         nxt.qu = qu_nxt;
         nxt.qv = qv_nxt;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k+1] <= nxt;
         end
      end
   end

   // CORDIC entry: quadrant from the top angle bits, rest into z
   always_ff @(posedge clock) begin
      if (adv) begin
         cor_ff[0].xt      <= uvs_pkg::CORDIC_X0;
         cor_ff[0].yt      <= '0;
         cor_ff[0].zt      <= {2'b00, div_ff[DS].qa[AB-3:0]};
         cor_ff[0].xp      <= uvs_pkg::CORDIC_X0;
         cor_ff[0].yp      <= '0;
         cor_ff[0].zp      <= {2'b00, div_ff[DS].qb[AB-3:0]};
         cor_ff[0].qt      <= uvs_pkg::quad_type'(div_ff[DS].qa[AB-1:AB-2]);
         cor_ff[0].qp      <= uvs_pkg::quad_type'(div_ff[DS].qb[AB-1:AB-2]);
         cor_ff[0].qu      <= div_ff[DS].qu;
         cor_ff[0].qv      <= div_ff[DS].qv;
         cor_ff[0].oor     <= div_ff[DS].oor;
         cor_ff[0].u_clamp <= div_ff[DS].u_clamp;
         cor_ff[0].v_clamp <= div_ff[DS].v_clamp;
      end
   end

   // rotation-mode CORDIC for both angles side by side
   for (genvar i = 0; i < CS; i++) begin : g_cor
      cor_type              nxt;
      logic signed [CB-1:0] atan_i;

      assign atan_i = uvs_pkg::atan_turn(i);

      always_comb begin
         nxt = cor_ff[i];
         if (!cor_ff[i].zt[CB-1]) begin
            nxt.xt = cor_ff[i].xt - (cor_ff[i].yt >>> i);
            nxt.yt = cor_ff[i].yt + (cor_ff[i].xt >>> i);
            nxt.zt = cor_ff[i].zt - atan_i;
         end else begin
            nxt.xt = cor_ff[i].xt + (cor_ff[i].yt >>> i);
            nxt.yt = cor_ff[i].yt - (cor_ff[i].xt >>> i);
            nxt.zt = cor_ff[i].zt + atan_i;
         end
         if (!cor_ff[i].zp[CB-1]) begin
            nxt.xp = cor_ff[i].xp - (cor_ff[i].yp >>> i);
            nxt.yp = cor_ff[i].yp + (cor_ff[i].xp >>> i);
            nxt.zp = cor_ff[i].zp - atan_i;
         end else begin
            nxt.xp = cor_ff[i].xp + (cor_ff[i].yp >>> i);
            nxt.yp = cor_ff[i].yp - (cor_ff[i].xp >>> i);
            nxt.zp = cor_ff[i].zp + atan_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cor_ff[i+1] <= nxt;
         end
      end
   end

   // quadrant fold and sin(theta) products
   always_comb begin
      logic [2*CB-1:0]      cs_t, cs_p;
      logic signed [CB-1:0] sn, cp, sp;
      cs_t = quad_map(cor_ff[CS].qt, cor_ff[CS].xt, cor_ff[CS].yt);
      cs_p = quad_map(cor_ff[CS].qp, cor_ff[CS].xp, cor_ff[CS].yp);
      sn   = $signed(cs_t[CB-1:0]);
      cp   = $signed(cs_p[2*CB-1:CB]);
      sp   = $signed(cs_p[CB-1:0]);
      prod_in.px      = sn * cp;
      prod_in.py      = sn * sp;
      prod_in.ct      = $signed(cs_t[2*CB-1:CB]);
      prod_in.qu      = cor_ff[CS].qu;
      prod_in.qv      = cor_ff[CS].qv;
      prod_in.oor     = cor_ff[CS].oor;
      prod_in.u_clamp = cor_ff[CS].u_clamp;
      prod_in.v_clamp = cor_ff[CS].v_clamp;
   end

   // round to Q1.15 and saturate
   always_comb begin
      logic signed [CB-1:0] rz;
      logic signed [PB-1:0] rz_w;
      rz   = (prod_ff.ct + CT_HALF) >>> 15;
      rz_w = rz;
      norm_in.nx      = sat_q15((prod_ff.px + PROD_HALF) >>> 45);
      norm_in.ny      = sat_q15((prod_ff.py + PROD_HALF) >>> 45);
      norm_in.nz      = sat_q15(rz_w);
      norm_in.qu      = prod_ff.qu;
      norm_in.qv      = prod_ff.qv;
      norm_in.oor     = prod_ff.oor;
      norm_in.u_clamp = prod_ff.u_clamp;
      norm_in.v_clamp = prod_ff.v_clamp;
   end

   // radius times normal
   always_comb begin
      logic signed [RB_RAD-1:0] rad_s;
      rad_s     = $signed({1'b0, cfg.radius});
      mul_in.mx = rad_s * norm_ff.nx;
      mul_in.my = rad_s * norm_ff.ny;
      mul_in.mz = rad_s * norm_ff.nz;
      mul_in.n  = norm_ff;
   end

   // final rounding, texture clamps and packing
   always_comb begin
      logic signed [MB-1:0] px, py, pz;
      logic [TB-1:0]        tu, tv;
      px = (mul_ff.mx + POS_HALF) >>> 15;
      py = (mul_ff.my + POS_HALF) >>> 15;
      pz = (mul_ff.mz + POS_HALF) >>> 15;
      tu = mul_ff.n.u_clamp ? TEX_ONE : mul_ff.n.qu;
      tv = mul_ff.n.v_clamp ? '0 : TB'(TEX_ONE - mul_ff.n.qv);
      out_data_in = uvs_pkg::RSP_DATA_BITS'({tv, tu, mul_ff.n.nz, mul_ff.n.ny, mul_ff.n.nx,
                                             pz[uvs_pkg::POS_BITS-1:0],
                                             py[uvs_pkg::POS_BITS-1:0],
                                             px[uvs_pkg::POS_BITS-1:0]});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff     <= prod_in;
         norm_ff     <= norm_in;
         mul_ff      <= mul_in;
         out_data_ff <= out_data_in;
         out_user_ff <= mul_ff.n.oor;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   `UVS_ASSERT(a_stall_holds, !adv |=> ($stable(dv_ff) && $stable(cv_ff) && $stable(mv_ff)), "pipe moved while output held")
   `UVS_ASSERT(a_tex_u_range, out_valid_ff |-> (out_data_ff[3*uvs_pkg::POS_BITS+3*NB +: TB] <= TEX_ONE), "texture u above one")

endmodule

// ===== rtl/uv_sphere_vertex_gen.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Ports                 | Transaction
// req     | in        | req_t{valid,ready,data} | ring and sector index
// rsp     | out       | rsp_t{valid,ready,data,user} | one vertex, tuser = index out of range
// csr     | in        | csr_{valid,ready,index,data} | register write, always ready
//
// One vertex per cycle sustained while the output is not held. 67 register stages:
// front stage, queue slot, 44 divider stages (an entry stage, then one quotient bit
// each), 17 CORDIC stages, 3 arithmetic stages and the output register.
// Reset is synchronous and clears all valid bits and sets the registers to
// radius 1.0, 32 sectors, 16 stacks. A held output stalls the whole back pipe;
// the two-entry queue and the front stage take three more requests, then
// req_tready drops.

module uv_sphere_vertex_gen (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [9:0] ring_index, [19:10] sector_index
   input  logic [uvs_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z, [66:51] normal_x,
   // [82:67] normal_y, [98:83] normal_z, [114:99] tex_u, [130:115] tex_v
   output logic [uvs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // [0] index_out_of_range
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [uvs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [uvs_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic [uvs_pkg::RADIUS_BITS-1:0] radius_ff;
   logic [uvs_pkg::INDEX_BITS-1:0]  sectors_ff, stacks_ff;
   uvs_pkg::cfg_type                cfg;
   logic                            push_valid, push_ready, pop_valid, pop_ready;
   uvs_pkg::work_type               push_item, pop_item;

   assign csr_ready = 1'b1;

   // configuration registers; unknown indices are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= uvs_pkg::RADIUS_RESET;
         sectors_ff <= uvs_pkg::SECTOR_RESET;
         stacks_ff  <= uvs_pkg::STACK_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == uvs_pkg::CSR_RADIUS) begin
            radius_ff <= csr_data[uvs_pkg::RADIUS_BITS-1:0];
         end
         if (csr_index == uvs_pkg::CSR_SECTORS) begin
            sectors_ff <= csr_data[uvs_pkg::INDEX_BITS-1:0];
         end
         if (csr_index == uvs_pkg::CSR_STACKS) begin
            stacks_ff <= csr_data[uvs_pkg::INDEX_BITS-1:0];
         end
      end
   end

   // a zero count behaves as one
   always_comb begin
      cfg.radius  = radius_ff;
      cfg.sectors = (sectors_ff == '0) ? uvs_pkg::INDEX_BITS'(1) : sectors_ff;
      cfg.stacks  = (stacks_ff == '0) ? uvs_pkg::INDEX_BITS'(1) : stacks_ff;
   end

   uvs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   uvs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   uvs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/vertex_checker.sv =====
`timescale 1ns / 1ps

module vertex_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [uvs_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [uvs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                               rsp_tuser,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [uvs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [uvs_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                 fail_count,
   output int                                 vertices_pending
);

   typedef struct {
      logic [uvs_pkg::RSP_FIELD_BITS-1:0] fields;
      logic                               oor;
   } vertex_type;

   // atan(2^-i) in turns, Q0.32
   localparam longint ATAN_TURNS [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

   logic [15:0] cur_radius;
   logic [9:0]  cur_sectors;
   logic [9:0]  cur_stacks;
   vertex_type  vertex_queue[$];

   // floor shift of a signed value
   function automatic longint fshr(longint v, int s);
      return v >>> s;
   endfunction

   // quadrant-folded CORDIC sine and cosine of a Q0.32 turn
   function automatic void turn_sin_cos(logic [31:0] t, output longint c, output longint s);
      longint x, y, z, dx, dy;
      uvs_pkg::quad_type q;
      x = 64'sd652032874;
      y = 0;
      z = longint'(t[29:0]);
      for (int i = 0; i < uvs_pkg::CORDIC_USED; i++) begin
         dx = fshr(y, i);
         dy = fshr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TURNS[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TURNS[i];
         end
      end
      q = uvs_pkg::quad_type'(t[31:30]);
      unique case (q)
         uvs_pkg::QUAD_0: begin c = x;  s = y;  end
         uvs_pkg::QUAD_1: begin c = -y; s = x;  end
         uvs_pkg::QUAD_2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint round_q15(longint v, int sh);
      longint r;
      r = fshr(v + (64'sd1 <<< (sh - 1)), sh);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic logic [16:0] scale_position(longint n);
      return 17'(fshr(longint'(cur_radius) * n + 16384, 15));
   endfunction

   // vertex expected for one ring/sector pair
   function automatic vertex_type predict_vertex(logic [9:0] ring, logic [9:0] sector);
      vertex_type v;
      longint unsigned st, se, u, pv;
      logic [31:0] theta, phi;
      longint ct, sn, cp, sp, nx, ny, nz;
      st = (cur_stacks == 0) ? 1 : cur_stacks;
      se = (cur_sectors == 0) ? 1 : cur_sectors;
      theta = 32'(((longint'(ring) << 32) + st) / (2 * st));
      phi   = 32'(((longint'(sector) << 33) + se) / (2 * se));
      turn_sin_cos(theta, ct, sn);
      turn_sin_cos(phi, cp, sp);
      nx = round_q15(sn * cp, 45);
      ny = round_q15(sn * sp, 45);
      nz = round_q15(ct, 15);
      u = ((longint'(sector) << 16) + se) / (2 * se);
      if (u > 32768) u = 32768;
      pv = ((longint'(ring) << 16) + st) / (2 * st);
      if (pv > 32768) pv = 32768;
      v.fields = {16'(32768 - pv), 16'(u), 16'(nz), 16'(ny), 16'(nx),
                  scale_position(nz), scale_position(ny), scale_position(nx)};
      v.oor = (ring > st) || (sector > se);
      return v;
   endfunction

   function automatic void compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // track registers, queue predictions, compare vertices
   always @(posedge clock) begin
      vertex_type want;
      if (reset) begin
         cur_radius  <= uvs_pkg::RADIUS_RESET;
         cur_sectors <= uvs_pkg::SECTOR_RESET;
         cur_stacks  <= uvs_pkg::STACK_RESET;
         fail_count  = 0;
         vertex_queue.delete();
      end else begin
         if (req_tvalid && req_tready)
            vertex_queue.insert(vertex_queue.size(),
                                predict_vertex(req_tdata[9:0], req_tdata[19:10]));
         if (rsp_tvalid && rsp_tready) begin
            if (vertex_queue.size() == 0) begin
               $error("unexpected vertex transaction");
               fail_count++;
            end else begin
               want = vertex_queue.pop_front();
               compare_field("pos_x", want.fields[16:0], rsp_tdata[16:0]);
               compare_field("pos_y", want.fields[33:17], rsp_tdata[33:17]);
               compare_field("pos_z", want.fields[50:34], rsp_tdata[50:34]);
               compare_field("normal_x", want.fields[66:51], rsp_tdata[66:51]);
               compare_field("normal_y", want.fields[82:67], rsp_tdata[82:67]);
               compare_field("normal_z", want.fields[98:83], rsp_tdata[98:83]);
               compare_field("tex_u", want.fields[114:99], rsp_tdata[114:99]);
               compare_field("tex_v", want.fields[130:115], rsp_tdata[130:115]);
               compare_field("index_out_of_range", want.oor, rsp_tuser);
            end
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               uvs_pkg::CSR_RADIUS:  cur_radius  <= csr_data;
               uvs_pkg::CSR_SECTORS: cur_sectors <= csr_data[9:0];
               uvs_pkg::CSR_STACKS:  cur_stacks  <= csr_data[9:0];
               default: ;
            endcase
         end
      end
      vertices_pending = vertex_queue.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   logic                               clock = 0;
   logic                               reset = 1;
   logic                               req_tvalid = 0;
   logic                               req_tready;
   logic [uvs_pkg::REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 0;
   logic [uvs_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                               rsp_tuser;
   logic                               csr_valid = 0;
   logic                               csr_ready;
   logic [uvs_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [uvs_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;
   int                                 fail_count;
   int                                 vertices_pending;
   int                                 hold_cycles = 0;
   logic                               long_hold_req = 0;
   logic                               long_hold_done = 0;
   logic [9:0]                         cfg_sectors = 32;
   logic [9:0]                         cfg_stacks = 16;

   always #10 clock = ~clock;

   uv_sphere_vertex_gen dut (.*);

   vertex_checker checker_i (.*);

   // a vertex transaction after a random gap; tvalid stays up for the next one
   task automatic send_vertex(logic [9:0] ring, logic [9:0] sector);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= uvs_pkg::REQ_DATA_BITS'({sector, ring});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_register(uvs_pkg::csr_index_type idx, logic [15:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
      if (idx == uvs_pkg::CSR_SECTORS) cfg_sectors = value[9:0];
      if (idx == uvs_pkg::CSR_STACKS) cfg_stacks = value[9:0];
   endtask

   task automatic drain;
      req_tvalid <= 0;
      @(posedge clock);
      while (vertices_pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // random index pair, mostly on the sphere
   task automatic send_random(int count);
      logic [9:0] r, s;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            r = 10'($urandom);
            s = 10'($urandom);
         end else begin
            r = 10'($urandom_range(0, cfg_stacks));
            s = 10'($urandom_range(0, cfg_sectors));
         end
         send_vertex(r, s);
      end
   endtask

   // receiver stalls, with one long hold-off
   always @(posedge clock) begin
      if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1;
         hold_cycles    <= 200;
         rsp_tready     <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 0;
      end else if (rsp_tready && rsp_tvalid && $urandom_range(0, 3) == 0) begin
         hold_cycles <= $urandom_range(1, 12);
         rsp_tready  <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // poles, seam, extremes, out of range indices at reset settings
      send_vertex(0, 0);
      send_vertex(16, 32);
      send_vertex(8, 8);
      send_vertex(8, 16);
      send_vertex(8, 24);
      send_vertex(17, 0);
      send_vertex(0, 33);
      send_vertex(1023, 1023);
      send_vertex(10'h155, 10'h2AA);
      send_vertex(10'h2AA, 10'h155);
      drain();

      // zero counts, small counts, maximum radius
      write_register(uvs_pkg::CSR_RADIUS, 16'hFFFF);
      write_register(uvs_pkg::CSR_SECTORS, 0);
      write_register(uvs_pkg::CSR_STACKS, 0);
      send_vertex(0, 0);
      send_vertex(1, 1);
      send_vertex(2, 3);
      drain();
      write_register(uvs_pkg::CSR_SECTORS, 1);
      write_register(uvs_pkg::CSR_STACKS, 2);
      send_vertex(1, 0);
      send_vertex(2, 1);
      send_vertex(3, 2);
      drain();
      // unknown register index is ignored
      csr_valid <= 1;
      csr_index <= 2'd3;
      csr_data  <= 16'h1234;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;

      // long hold-off while requests keep coming
      long_hold_req <= 1;
      send_random(150);
      drain();

      // random settings, extremes among them
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               write_register(uvs_pkg::CSR_RADIUS, 0);
               write_register(uvs_pkg::CSR_SECTORS, 1023);
               write_register(uvs_pkg::CSR_STACKS, 1023);
            end
            1: begin
               write_register(uvs_pkg::CSR_RADIUS, 16'hFFFF);
               write_register(uvs_pkg::CSR_SECTORS, 3);
               write_register(uvs_pkg::CSR_STACKS, 2);
            end
            default: begin
               write_register(uvs_pkg::CSR_RADIUS, 16'($urandom));
               write_register(uvs_pkg::CSR_SECTORS, 16'($urandom_range(3, 1023)));
               write_register(uvs_pkg::CSR_STACKS, 16'($urandom_range(2, 1023)));
            end
         endcase
         send_random(170);
         drain();
      end

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
